[rtl/core/sha1_stream_hasher_defines.svh]
// Assertion macros shared by the SHA-1 stream hasher RTL.
// The macros expect signals named clk and rst in the scope that uses them.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1SH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1SH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/sha1sh_pkg.sv]
// Shared types, constants and helper functions for the SHA-1 stream hasher.
// No dependencies; every RTL module imports this package.
package sha1sh_pkg;

  localparam int unsigned NumHashWords = 5;
  localparam int unsigned NumRounds    = 80;
  localparam logic [5:0]  LenOffset    = 6'd56;
  localparam logic [7:0]  PadMarker    = 8'h80;
  localparam logic [2:0]  LastWordIdx  = 3'(NumHashWords - 1);
  localparam logic [6:0]  LastRound    = 7'(NumRounds - 1);

  localparam logic [31:0] InitH0 = 32'h67452301;
  localparam logic [31:0] InitH1 = 32'hEFCDAB89;
  localparam logic [31:0] InitH2 = 32'h98BADCFE;
  localparam logic [31:0] InitH3 = 32'h10325476;
  localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } dig_item_t;

  // Source of the byte written into the block buffer.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put;
    byte_src_t  put_src;
    logic       count_bits;
    logic       load_work;
    logic       round;
    logic [6:0] round_idx;
    logic       add_chain;
    logic       init;
    logic [2:0] out_idx;
  } sha1sh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
  } sha1sh_stat_t;

  function automatic logic [31:0] round_const(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_func(input logic [6:0] r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

[rtl/core/sha1sh_datapath.sv]
// Datapath of the SHA-1 stream hasher: block buffer and message schedule,
// working variables, chaining words and bit count. Depends on sha1sh_pkg.
module sha1sh_datapath import sha1sh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sha1sh_cmd_t  cmd,
  input  msg_item_t    msg_item,
  output sha1sh_stat_t stat,
  output logic [31:0]  digest_word
);

  // Sixteen words, word 0 in the top bits. Bytes shift in at the bottom;
  // during the rounds the same register acts as the schedule shift line.
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  bits;
  logic [31:0]  h0, h1, h2, h3, h4;
  logic [31:0]  a, b, c, d, e;

  logic [7:0]   put_byte;
  logic [63:0]  len_shift;
  logic [31:0]  w_cur;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;
  logic [31:0]  t_sum;

  assign len_shift = bits << {fill[2:0], 3'b000};

  always_comb begin
    case (cmd.put_src)
      SRC_DATA: put_byte = msg_item.data_byte;
      SRC_MARK: put_byte = PadMarker;
      SRC_ZERO: put_byte = 8'h00;
      SRC_LEN:  put_byte = len_shift[63:56];
      default:  put_byte = 8'h00;
    endcase
  end

  assign w_cur = blk[511:480];
  assign w_mix = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a[26:0], a[31:27]} + round_func(cmd.round_idx, b, c, d) + e
               + round_const(cmd.round_idx) + w_cur;

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      blk <= {blk[503:0], put_byte};
    end else if (cmd.round) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.load_work) begin
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (cmd.round) begin
      a <= t_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      h0   <= InitH0;
      h1   <= InitH1;
      h2   <= InitH2;
      h3   <= InitH3;
      h4   <= InitH4;
      bits <= '0;
      fill <= '0;
    end else begin
      if (cmd.add_chain) begin
        h0 <= h0 + a;
        h1 <= h1 + b;
        h2 <= h2 + c;
        h3 <= h3 + d;
        h4 <= h4 + e;
      end
      if (cmd.count_bits) begin
        bits <= bits + 64'd8;
      end
      if (cmd.put) begin
        fill <= fill + 6'd1;
      end
    end
  end

  always_comb begin
    case (cmd.out_idx)
      3'd0:    digest_word = h0;
      3'd1:    digest_word = h1;
      3'd2:    digest_word = h2;
      3'd3:    digest_word = h3;
      3'd4:    digest_word = h4;
      default: digest_word = h4;
    endcase
  end

  assign stat.fill = fill;

endmodule

[rtl/core/sha1sh_ctrl.sv]
// Controller of the SHA-1 stream hasher: sequences byte intake, rounds,
// padding and digest output. Depends on sha1sh_pkg.
module sha1sh_ctrl import sha1sh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         msg_valid,
  input  msg_item_t    msg_item,
  output logic         msg_stall,
  output logic         dig_valid,
  input  logic         dig_stall,
  input  sha1sh_stat_t stat,
  output sha1sh_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_ADD   = 5'b00100,
    S_PAD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t     state, state_next;
  state_t     resume, resume_next;
  logic [6:0] round, round_next;
  logic [2:0] out_idx, out_idx_next;
  logic       marker_done, marker_done_next;
  logic       len_phase, len_phase_next;
  logic       block_full;

  assign block_full = (stat.fill == 6'd63);

  always_comb begin
    state_next       = state;
    resume_next      = resume;
    round_next       = round;
    out_idx_next     = out_idx;
    marker_done_next = marker_done;
    len_phase_next   = len_phase;
    cmd              = '0;
    cmd.put_src      = SRC_DATA;
    cmd.round_idx    = round;
    cmd.out_idx      = out_idx;
    msg_stall        = (state != S_IDLE);
    dig_valid        = (state == S_OUT);

    case (state)
      S_IDLE: begin
        if (msg_valid) begin
          if (msg_item.byte_valid) begin
            cmd.put        = 1'b1;
            cmd.count_bits = 1'b1;
          end
          if (msg_item.message_end) begin
            marker_done_next = 1'b0;
            len_phase_next   = 1'b0;
          end
          if (msg_item.byte_valid && block_full) begin
            cmd.load_work = 1'b1;
            round_next    = '0;
            state_next    = S_ROUND;
            resume_next   = msg_item.message_end ? S_PAD : S_IDLE;
          end else if (msg_item.message_end) begin
            state_next = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (round == LastRound) begin
          state_next = S_ADD;
        end else begin
          round_next = round + 7'd1;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        state_next    = resume;
      end
      S_PAD: begin
        cmd.put = 1'b1;
        if (!marker_done) begin
          cmd.put_src      = SRC_MARK;
          marker_done_next = 1'b1;
        end else if (len_phase || stat.fill == LenOffset) begin
          cmd.put_src    = SRC_LEN;
          len_phase_next = 1'b1;
        end else begin
          cmd.put_src = SRC_ZERO;
        end
        if (block_full) begin
          cmd.load_work = 1'b1;
          round_next    = '0;
          out_idx_next  = '0;
          state_next    = S_ROUND;
          resume_next   = (cmd.put_src == SRC_LEN) ? S_OUT : S_PAD;
        end
      end
      S_OUT: begin
        if (!dig_stall) begin
          if (out_idx == LastWordIdx) begin
            cmd.init   = 1'b1;
            state_next = S_IDLE;
          end else begin
            out_idx_next = out_idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resume      <= S_IDLE;
      round       <= '0;
      out_idx     <= '0;
      marker_done <= 1'b0;
      len_phase   <= 1'b0;
    end else begin
      state       <= state_next;
      resume      <= resume_next;
      round       <= round_next;
      out_idx     <= out_idx_next;
      marker_done <= marker_done_next;
      len_phase   <= len_phase_next;
    end
  end

endmodule

[rtl/core/sha1_stream_hasher.sv]
// Top level of the SHA-1 stream hasher: controller plus datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl, sha1sh_datapath and the defines header.
//
// The block hashes a byte stream with SHA-1. Each input transfer carries at
// most one message byte and may mark the end of the message. While a block
// fills, one byte is taken per cycle. The 64th byte of a block starts the
// compression, which runs one round per cycle through a single round unit and
// a 16-word schedule shift line, then adds into the chaining words; input
// stays stalled through the rounds and the add. On an end transfer the block
// writes the 0x80 marker, zero fill and the 64-bit big-endian bit count one
// byte per cycle outside compressions, running one or two more compressions,
// then presents the digest as five output transfers, word 0 first, with
// final_word set on word 4. Input stays stalled until the last digest word is
// taken; the block then starts a fresh message. A transfer with neither a byte
// nor an end mark changes nothing.
`include "sha1_stream_hasher_defines.svh"
module sha1_stream_hasher import sha1sh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_stall,
  input  msg_item_t msg_item,
  output logic      dig_valid,
  input  logic      dig_stall,
  output dig_item_t dig_item
);

  sha1sh_cmd_t  cmd;
  sha1sh_stat_t stat;
  logic [31:0]  digest_word;

  // The controller decides everything; the datapath only executes commands.
  sha1sh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_item  (msg_item),
    .msg_stall (msg_stall),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_item    (msg_item),
    .stat        (stat),
    .digest_word (digest_word)
  );

  // Digest words come straight from the chaining registers, which hold
  // still while the output is presented.
  assign dig_item.digest_word = digest_word;
  assign dig_item.word_index  = cmd.out_idx;
  assign dig_item.final_word  = (cmd.out_idx == LastWordIdx);

  // No input is taken while a digest is being delivered.
  `SHA1SH_ASSERT_NOW(a_no_input_during_output, dig_valid, msg_stall, "input open during digest output")
  // After the last word the output channel goes quiet.
  `SHA1SH_ASSERT_NEXT(a_output_ends, dig_valid && !dig_stall && dig_item.final_word, !dig_valid, "digest output continued past the last word")
  // Words follow one another in order without gaps.
  `SHA1SH_ASSERT_NEXT(a_word_order, dig_valid && !dig_stall && !dig_item.final_word, dig_valid && (dig_item.word_index == $past(dig_item.word_index) + 3'd1), "digest words out of order")

endmodule
